@@ rtl/mat3_inverse_unit_assert.svh @@
// assertion macros for the 3x3 inverse unit
`ifndef MAT3_INVERSE_UNIT_ASSERT_SVH
`define MAT3_INVERSE_UNIT_ASSERT_SVH

// clocked check, off while reset is held
`define MI3_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also runs through reset
`define MI3_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

    localparam int ELEM_W  = 32;
    localparam int THR_W   = 31;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int DET_W   = ELEM_W + COF_W + 2;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic        [COF_W-1:0]  t_cof_mag;
    typedef logic signed [DET_W-1:0]  t_det;
    typedef logic        [DET_W-1:0]  t_det_mag;

    typedef struct packed {
        t_elem m00;
        t_elem m01;
        t_elem m02;
        t_elem m10;
        t_elem m11;
        t_elem m12;
        t_elem m20;
        t_elem m21;
        t_elem m22;
    } t_in_item;

    typedef struct packed {
        t_elem inv00;
        t_elem inv01;
        t_elem inv02;
        t_elem inv10;
        t_elem inv11;
        t_elem inv12;
        t_elem inv20;
        t_elem inv21;
        t_elem inv22;
        t_elem det_value;
        logic  singular;
    } t_out_item;

    // per-item status that rides alongside the divider lanes
    typedef struct packed {
        logic  singular;
        t_elem det_value;
    } t_side;

    localparam t_elem ELEM_MAX = t_elem'({1'b0, {(ELEM_W-1){1'b1}}});
    localparam t_elem ELEM_MIN = t_elem'({1'b1, {(ELEM_W-1){1'b0}}});

    // apply sign to a magnitude and clamp to the element range
    function automatic t_elem sat_mag(input logic neg, input logic big,
                                      input logic [ELEM_W-1:0] mag);
        t_elem r;
        if (big || mag[ELEM_W-1]) begin
            r = neg ? ELEM_MIN : ELEM_MAX;
        end else begin
            r = neg ? t_elem'(-mag) : t_elem'(mag);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/mi3_cofactor.sv @@
`default_nettype none
module mi3_cofactor (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  mi3_pkg::t_in_item i_mat,
    output logic             o_valid,
    output mi3_pkg::t_cof    o_cof [9],
    output mi3_pkg::t_elem   o_row0 [3]
);
    import mi3_pkg::*;

    // cofactor t[i] = m[a]*m[b] - m[c]*m[d]
    localparam int unsigned IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    t_elem m [9];
    t_prod pa [9];
    t_prod pb [9];
    t_prod r_pa [9];
    t_prod r_pb [9];
    t_elem r_row1 [3];
    t_elem r_row2 [3];
    t_cof  r_cof [9];
    logic  r_v1;
    logic  r_v2;

    assign m[0] = i_mat.m00;
    assign m[1] = i_mat.m01;
    assign m[2] = i_mat.m02;
    assign m[3] = i_mat.m10;
    assign m[4] = i_mat.m11;
    assign m[5] = i_mat.m12;
    assign m[6] = i_mat.m20;
    assign m[7] = i_mat.m21;
    assign m[8] = i_mat.m22;

    // eighteen element products
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            pa[i] = m[IA[i]] * m[IB[i]];
            pb[i] = m[IC[i]] * m[ID[i]];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // product stage, then difference stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_pa[i]  <= pa[i];
                r_pb[i]  <= pb[i];
                r_cof[i] <= t_cof'(r_pa[i]) - t_cof'(r_pb[i]);
            end
            for (int j = 0; j < 3; j++) begin
                r_row1[j] <= m[j];
                r_row2[j] <= r_row1[j];
            end
        end
    end

    assign o_valid = r_v2;
    assign o_cof   = r_cof;
    assign o_row0  = r_row2;

endmodule
`default_nettype wire

@@ rtl/mi3_det.sv @@
`default_nettype none
module mi3_det #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  mi3_pkg::t_cof             i_cof [9],
    input  mi3_pkg::t_elem            i_row0 [3],
    input  logic [mi3_pkg::THR_W-1:0] i_thr,
    output logic                      o_valid,
    output mi3_pkg::t_side            o_side,
    output mi3_pkg::t_cof_mag         o_cof_mag [9],
    output logic [8:0]                o_cof_neg,
    output mi3_pkg::t_det_mag         o_den
);
    import mi3_pkg::*;

    // first-row expansion uses cofactors 0, 3 and 6
    localparam int unsigned TI [3] = '{0, 3, 6};

    t_cof     pl [3];
    t_cof     ph [3];
    t_cof     r_pl [3];
    t_cof     r_ph [3];
    t_cof     r_a_cof [9];
    t_cof     r_b_cof [9];
    t_det     det_sum;
    t_det     r_b_det;
    t_det_mag r_c_den;
    logic     r_c_neg;
    t_cof_mag r_c_cmag [9];
    logic [8:0] r_c_cneg;
    t_det_mag r_d_den;
    t_cof_mag r_d_cmag [9];
    logic [8:0] r_d_cneg;
    t_side    r_d_side;
    logic     r_va, r_vb, r_vc, r_vd;
    t_det_mag thr_wide;
    t_det_mag det_q;

    // split each cofactor into low and high halves to keep multipliers narrow
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            pl[j] = i_row0[j] * $signed({1'b0, i_cof[TI[j]][ELEM_W-1:0]});
            ph[j] = i_row0[j] * $signed(i_cof[TI[j]][COF_W-1:ELEM_W]);
        end
    end

    // recombine partial products into the exact determinant
    always_comb begin
        det_sum = '0;
        for (int j = 0; j < 3; j++) begin
            det_sum = det_sum + (t_det'(r_ph[j]) <<< ELEM_W) + t_det'(r_pl[j]);
        end
    end

    assign thr_wide = t_det_mag'(i_thr) << (2 * FRAC_BITS);
    assign det_q    = r_c_den >> (2 * FRAC_BITS);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // partial products, sum, magnitudes, singular test
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl    <= pl;
            r_ph    <= ph;
            r_a_cof <= i_cof;
            r_b_det <= det_sum;
            r_b_cof <= r_a_cof;
            r_c_neg <= r_b_det[DET_W-1];
            r_c_den <= r_b_det[DET_W-1] ? t_det_mag'(-r_b_det) : t_det_mag'(r_b_det);
            for (int i = 0; i < 9; i++) begin
                r_c_cneg[i] <= r_b_cof[i][COF_W-1];
                r_c_cmag[i] <= r_b_cof[i][COF_W-1] ? t_cof_mag'(-r_b_cof[i])
                                                   : t_cof_mag'(r_b_cof[i]);
            end
            r_d_den            <= r_c_den;
            r_d_cmag           <= r_c_cmag;
            // quotient sign combines cofactor and determinant signs
            r_d_cneg           <= r_c_cneg ^ {9{r_c_neg}};
            r_d_side.singular  <= (r_c_den <= thr_wide);
            r_d_side.det_value <= sat_mag(r_c_neg, |det_q[DET_W-1:ELEM_W],
                                          det_q[ELEM_W-1:0]);
        end
    end

    assign o_valid   = r_vd;
    assign o_side    = r_d_side;
    assign o_cof_mag = r_d_cmag;
    assign o_cof_neg = r_d_cneg;
    assign o_den     = r_d_den;

endmodule
`default_nettype wire

@@ rtl/mi3_div_lane.sv @@
`default_nettype none
module mi3_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  mi3_pkg::t_cof_mag i_num_mag,
    input  logic              i_num_neg,
    input  mi3_pkg::t_det_mag i_den,
    output mi3_pkg::t_elem    o_quo
);
    import mi3_pkg::*;

    localparam int STEPS = ELEM_W;
    localparam int NUM_W = COF_W + 2 * FRAC_BITS;

    logic [NUM_W-1:0]  num_full;
    logic              ovf0;
    t_det_mag          r_rem  [STEPS];
    logic [STEPS-1:0]  r_tail [STEPS];
    t_det_mag          r_den  [STEPS];
    logic [ELEM_W-1:0] r_q    [STEPS+1];
    logic              r_ovf  [STEPS+1];
    logic              r_neg  [STEPS+1];
    t_elem             r_quo;

    // numerator scaled by 2^(2*frac); quotient too wide when head >= divisor
    assign num_full = {i_num_mag, {(2 * FRAC_BITS){1'b0}}};
    assign ovf0     = t_det_mag'(num_full[NUM_W-1:STEPS]) >= i_den;

    // setup stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= t_det_mag'(num_full[NUM_W-1:STEPS]);
            r_tail[0] <= num_full[STEPS-1:0];
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= ovf0;
            r_neg[0]  <= i_num_neg;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar s = 1; s <= STEPS; s++) begin : g_step
        logic [DET_W:0] trial;
        logic           ge;

        assign trial = {r_rem[s-1], r_tail[s-1][STEPS-s]};
        assign ge    = trial >= {1'b0, r_den[s-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]   <= r_q[s-1] | (ELEM_W'(ge) << (STEPS - s));
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end

        if (s < STEPS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= ge ? DET_W'(trial - {1'b0, r_den[s-1]}) : DET_W'(trial);
                    r_tail[s] <= r_tail[s-1];
                    r_den[s]  <= r_den[s-1];
                end
            end
        end
    end

    // sign and clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= sat_mag(r_neg[STEPS], r_ovf[STEPS], r_q[STEPS]);
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

@@ rtl/mat3_inverse_unit.sv @@
`default_nettype none
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_data   (nine Q16.16 elements)
// output    out        o_valid / i_stall    o_data   (inverse, determinant, flag)
// config    in         i_cfg_we             i_cfg_data (singular threshold)
//
// one matrix enters per cycle while o_stall is low; the dividers work a bit per stage,
// one stage per quotient bit plus setup and clamp.
// all stages advance together whenever the output register is empty or taken.
// o_stall rises only while a result sits in the output register and i_stall is high.
// reset clears the valid bits and loads the threshold with 1.
module mat3_inverse_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  mi3_pkg::t_in_item         i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output mi3_pkg::t_out_item        o_data,
    input  logic                      i_cfg_we,
    input  logic [mi3_pkg::THR_W-1:0] i_cfg_data
);
    import mi3_pkg::*;

    localparam int DIV_LAT = ELEM_W + 2;
    localparam t_elem ONE  = t_elem'(1) << FRAC_BITS;

    logic              en;
    logic [THR_W-1:0]  r_thr;
    logic              cof_valid;
    t_cof              cof [9];
    t_elem             row0 [3];
    logic              det_valid;
    t_side             det_side;
    t_cof_mag          cof_mag [9];
    logic [8:0]        cof_neg;
    t_det_mag          den;
    t_elem             quo [9];
    t_side             r_side [DIV_LAT];
    logic              r_sv [DIV_LAT];
    t_out_item         n_out;
    t_out_item         r_out;
    logic              r_out_valid;

    // whole pipeline moves unless the result register is held
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    mi3_cofactor u_cofactor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_mat   (i_data),
        .o_valid (cof_valid),
        .o_cof   (cof),
        .o_row0  (row0)
    );

    mi3_det #(
        .FRAC_BITS (FRAC_BITS)
    ) u_det (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (cof_valid),
        .i_cof     (cof),
        .i_row0    (row0),
        .i_thr     (r_thr),
        .o_valid   (det_valid),
        .o_side    (det_side),
        .o_cof_mag (cof_mag),
        .o_cof_neg (cof_neg),
        .o_den     (den)
    );

    // nine divider lanes, one per inverse element
    for (genvar i = 0; i < 9; i++) begin : g_lane
        mi3_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_num_mag (cof_mag[i]),
            .i_num_neg (cof_neg[i]),
            .i_den     (den),
            .o_quo     (quo[i])
        );
    end

    // valid and status follow the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) begin
                r_sv[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sv[0] <= det_valid;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
            r_out_valid <= r_sv[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= det_side;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_out <= n_out;
        end
    end

    // identity replaces the quotients for a singular matrix
    always_comb begin
        if (r_side[DIV_LAT-1].singular) begin
            n_out.inv00 = ONE;
            n_out.inv01 = '0;
            n_out.inv02 = '0;
            n_out.inv10 = '0;
            n_out.inv11 = ONE;
            n_out.inv12 = '0;
            n_out.inv20 = '0;
            n_out.inv21 = '0;
            n_out.inv22 = ONE;
        end else begin
            n_out.inv00 = quo[0];
            n_out.inv01 = quo[1];
            n_out.inv02 = quo[2];
            n_out.inv10 = quo[3];
            n_out.inv11 = quo[4];
            n_out.inv12 = quo[5];
            n_out.inv20 = quo[6];
            n_out.inv21 = quo[7];
            n_out.inv22 = quo[8];
        end
        n_out.det_value = r_side[DIV_LAT-1].det_value;
        n_out.singular  = r_side[DIV_LAT-1].singular;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

@@ rtl/mi3_checker.sv @@
`default_nettype none
`include "mat3_inverse_unit_assert.svh"
module mi3_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input mi3_pkg::t_in_item         i_data,
    input logic                      o_valid,
    input logic                      i_stall,
    input mi3_pkg::t_out_item        o_data
);
    import mi3_pkg::*;

    localparam t_elem ONE = t_elem'(1) << FRAC_BITS;

    logic out_held;
    logic in_held;
    logic sing_out;
    logic ident_ok;

    assign out_held = o_valid && i_stall;
    assign in_held  = i_valid && o_stall;
    assign sing_out = o_valid && o_data.singular;
    assign ident_ok = o_data.inv00 == ONE && o_data.inv11 == ONE && o_data.inv22 == ONE
                   && o_data.inv01 == '0 && o_data.inv02 == '0 && o_data.inv10 == '0
                   && o_data.inv12 == '0 && o_data.inv20 == '0 && o_data.inv21 == '0;

    // a held result stays put
    `MI3_ASSERT(a_out_hold, i_clk, i_rst_n, out_held |=> o_valid && $stable(o_data), "result moved")

    // a stalled input transfer stays put
    `MI3_ASSERT(a_in_hold, i_clk, i_rst_n, in_held |=> i_valid && $stable(i_data), "input moved")

    // input backpressure only comes from a held result
    `MI3_ASSERT(a_stall_src, i_clk, i_rst_n, o_stall |-> out_held, "stray input stall")

    // singular flag carries the identity matrix
    `MI3_ASSERT(a_sing_ident, i_clk, i_rst_n, sing_out |-> ident_ok, "identity missing")

    // reset empties the pipeline
    `MI3_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind mat3_inverse_unit mi3_checker #(.FRAC_BITS(FRAC_BITS)) u_mi3_checker (.*);
`default_nettype wire

@@ bench/mat3_inverse_checker.sv @@
`default_nettype none
module mat3_inverse_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire mi3_pkg::t_in_item         i_in_data,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire mi3_pkg::t_out_item        i_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [mi3_pkg::THR_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mi3_pkg::*;

    typedef logic signed [127:0] t_wide;

    logic [THR_W-1:0] threshold;
    t_out_item        inverse_queue[$];
    string            field_name[10] = '{"inv00", "inv01", "inv02", "inv10", "inv11",
                                         "inv12", "inv20", "inv21", "inv22", "det_value"};

    // clamp a wide value to the element range
    function automatic t_elem clamp_elem(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = t_wide'(ELEM_MAX);
        lo = t_wide'(ELEM_MIN);
        if (v > hi) return ELEM_MAX;
        if (v < lo) return ELEM_MIN;
        return t_elem'(v);
    endfunction

    // exact adjugate inverse with truncating division
    function automatic t_out_item invert_matrix(input t_in_item d, input logic [THR_W-1:0] thr);
        t_wide     m[9];
        t_wide     c[9];
        t_wide     det;
        t_wide     det_mag;
        t_wide     thr_scaled;
        t_wide     scale;
        t_elem     res[9];
        t_out_item r;
        m[0] = t_wide'(d.m00); m[1] = t_wide'(d.m01); m[2] = t_wide'(d.m02);
        m[3] = t_wide'(d.m10); m[4] = t_wide'(d.m11); m[5] = t_wide'(d.m12);
        m[6] = t_wide'(d.m20); m[7] = t_wide'(d.m21); m[8] = t_wide'(d.m22);
        c[0] = m[4] * m[8] - m[5] * m[7];
        c[1] = m[2] * m[7] - m[1] * m[8];
        c[2] = m[1] * m[5] - m[2] * m[4];
        c[3] = m[5] * m[6] - m[3] * m[8];
        c[4] = m[0] * m[8] - m[2] * m[6];
        c[5] = m[2] * m[3] - m[0] * m[5];
        c[6] = m[3] * m[7] - m[4] * m[6];
        c[7] = m[1] * m[6] - m[0] * m[7];
        c[8] = m[0] * m[4] - m[1] * m[3];
        det = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
        scale = t_wide'(1) <<< 32;
        det_mag = (det < 0) ? -det : det;
        thr_scaled = t_wide'({1'b0, thr}) <<< 32;
        r.det_value = clamp_elem(det / scale);
        if (det_mag <= thr_scaled) begin
            for (int k = 0; k < 9; k++) res[k] = (k % 4 == 0) ? t_elem'(1 << 16) : '0;
            r.singular = 1'b1;
        end else begin
            for (int k = 0; k < 9; k++) res[k] = clamp_elem((c[k] <<< 32) / det);
            r.singular = 1'b0;
        end
        r.inv00 = res[0]; r.inv01 = res[1]; r.inv02 = res[2];
        r.inv10 = res[3]; r.inv11 = res[4]; r.inv12 = res[5];
        r.inv20 = res[6]; r.inv21 = res[7]; r.inv22 = res[8];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    // field-by-field compare against the oldest prediction
    task automatic compare_result(input t_out_item got, input t_out_item want);
        t_elem g;
        t_elem w;
        for (int k = 0; k < 10; k++) begin
            g = got[1 + (9 - k) * 32 +: 32];
            w = want[1 + (9 - k) * 32 +: 32];
            if (g !== w) report_mismatch(field_name[k], g, w);
        end
        if (got.singular !== want.singular)
            report_mismatch("singular", got.singular, want.singular);
    endtask

    initial o_errors = 0;
    assign o_pending = inverse_queue.size();

    // track threshold, predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold <= THR_W'(1);
        end else begin
            if (i_in_valid && !i_in_stall)
                inverse_queue.push_back(invert_matrix(i_in_data, threshold));
            if (i_out_valid && !i_out_stall) begin
                if (inverse_queue.size() == 0)
                    report_mismatch("unexpected transfer", 0, 0);
                else
                    compare_result(i_out_data, inverse_queue.pop_front());
            end
            if (i_cfg_we) threshold <= i_cfg_data;
        end
    end
endmodule
`default_nettype wire

@@ bench/tb_mat3_inverse_unit.sv @@
`default_nettype none
module tb_mat3_inverse_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mi3_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 280;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    t_in_item         i_data;
    logic             o_valid;
    logic             i_stall;
    t_out_item        o_data;
    logic             i_cfg_we;
    logic [THR_W-1:0] i_cfg_data;
    int               errors;
    int               pending;
    int               cycles;
    int               send_idle_pct;
    int               recv_stall_pct;

    mat3_inverse_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    mat3_inverse_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall and timeout watch
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_elem pick_elem(input int kind);
        case (kind)
            0: return t_elem'($signed($urandom_range(0, 2 * (4 << 16))) - (4 << 16));
            1: return t_elem'($urandom());
            default: begin
                case ($urandom_range(0, 5))
                    0: return ELEM_MAX;
                    1: return ELEM_MIN;
                    2: return '0;
                    3: return t_elem'(1);
                    4: return t_elem'(-1);
                    default: return t_elem'(1 << 16);
                endcase
            end
        endcase
    endfunction

    // mostly moderate matrices, some near-singular, some wide or extreme
    function automatic t_in_item random_matrix();
        t_in_item d;
        int       kind;
        int       sel;
        sel = $urandom_range(0, 99);
        kind = (sel < 55) ? 0 : (sel < 85) ? 1 : 2;
        d = {pick_elem(kind), pick_elem(kind), pick_elem(kind),
             pick_elem(kind), pick_elem(kind), pick_elem(kind),
             pick_elem(kind), pick_elem(kind), pick_elem(kind)};
        if (sel >= 40 && sel < 55) begin
            // third row is nearly the sum of the first two
            d.m20 = d.m00 + d.m10 + t_elem'($urandom_range(0, 3));
            d.m21 = d.m01 + d.m11;
            d.m22 = d.m02 + d.m12 - t_elem'($urandom_range(0, 3));
        end
        return d;
    endfunction

    task automatic send_matrix(input t_in_item d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= d;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold off until every result is back, then settle
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    t_in_item         directed[$];
    logic [THR_W-1:0] thr_list[5];
    int               idle_send[5];
    int               idle_recv[5];

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_stall <= 1'b0;
        cycles <= 0;
        send_idle_pct = 34;
        recv_stall_pct = 55;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity, zero, scaled, negative, tiny, saturating and extreme matrices
        directed.push_back({32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0,
                            32'sh0, 32'sh0, 32'sh10000});
        directed.push_back('0);
        directed.push_back({32'sh20000, 32'sh0, 32'sh0, 32'sh0, 32'sh20000, 32'sh0,
                            32'sh0, 32'sh0, 32'sh20000});
        directed.push_back({-32'sh10000, 32'sh0, 32'sh0, 32'sh0, -32'sh10000, 32'sh0,
                            32'sh0, 32'sh0, -32'sh10000});
        directed.push_back({32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh1, 32'sh0,
                            32'sh0, 32'sh0, 32'sh1});
        directed.push_back({32'sh800, 32'sh0, 32'sh0, 32'sh0, 32'sh800, 32'sh0,
                            32'sh0, 32'sh0, 32'sh800});
        directed.push_back({32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh0,
                            32'sh0, 32'sh0, 32'sh2});
        directed.push_back({32'sh10000, 32'sh0, 32'sh0, 32'sh0, -32'sh10000, 32'sh0,
                            32'sh0, 32'sh0, 32'sh2});
        directed.push_back({9{ELEM_MAX}});
        directed.push_back({9{ELEM_MIN}});
        directed.push_back({ELEM_MAX, ELEM_MIN, 32'sh0, 32'sh0, ELEM_MAX, ELEM_MIN,
                            ELEM_MIN, 32'sh0, ELEM_MAX});
        directed.push_back({ELEM_MIN, 32'sh0, 32'sh0, 32'sh0, ELEM_MIN, 32'sh0,
                            32'sh0, 32'sh0, ELEM_MIN});
        directed.push_back({ELEM_MAX, 32'sh0, 32'sh0, 32'sh0, ELEM_MAX, 32'sh0,
                            32'sh0, 32'sh0, ELEM_MAX});
        directed.push_back({32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
                            32'sh60000, 32'sh70000, 32'sh80000, 32'sh90000});
        directed.push_back({32'sh20000, 32'sh10000, 32'sh0, 32'sh10000, 32'sh30000,
                            32'sh10000, 32'sh0, 32'sh10000, 32'sh40000});
        directed.push_back({32'sh0, 32'sh10000, 32'sh0, 32'sh10000, 32'sh0, 32'sh0,
                            32'sh0, 32'sh0, 32'sh10000});
        directed.push_back({32'sh10, 32'sh0, 32'sh0, 32'sh0, 32'sh10, 32'sh0,
                            32'sh0, 32'sh0, 32'sh10});
        directed.push_back({32'shFFFFFFFF, 32'shAAAAAAAA, 32'sh55555555, 32'sh12345678,
                            32'sh0F0F0F0F, 32'shF0F0F0F0, 32'sh7FFF0001, 32'sh80000001,
                            32'sh3});

        // threshold settings per phase; first phase keeps the reset value
        thr_list = '{THR_W'(1), THR_W'(0), {THR_W{1'b1}}, THR_W'($urandom()), THR_W'(1)};
        idle_send = '{34, 34, 55, 55, 0};
        idle_recv = '{55, 55, 34, 34, 0};

        for (int p = 0; p < 5; p++) begin
            send_idle_pct = idle_send[p];
            recv_stall_pct = idle_recv[p];
            if (p != 0) write_threshold(thr_list[p]);
            foreach (directed[k]) send_matrix(directed[k]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_matrix(random_matrix());
                if (n == ITEMS_PER_PHASE / 2) drain();
            end
        end
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_cofactor.sv
rtl/mi3_det.sv
rtl/mi3_div_lane.sv
rtl/mat3_inverse_unit.sv
rtl/mi3_checker.sv
bench/mat3_inverse_checker.sv
bench/tb_mat3_inverse_unit.sv
